>>> hw/rtl/tvsc_pkg.sv
// Shared types and constants for the tensor view stride block.
// Used by tvsc_mul and tensor_view_stride_compute; depends on nothing.
`default_nettype none

package tvsc_pkg;

    // Largest rank that is stored for either shape
    localparam int MAX_RANK = 8;
    // Count of stored dimensions, 0 to MAX_RANK
    localparam int CNT_W    = $clog2(MAX_RANK + 1);
    // Index into the dimension stores
    localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    localparam int SIZE_W   = 32;
    localparam int STRIDE_W = 64;
    localparam int DIM_W    = 3;

    // Partial products per 64-bit wrapped product
    localparam int MUL_STEPS  = 3;
    localparam int MUL_STEP_W = 2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_LOAD,
        S_START,
        S_NUMEL_GO,
        S_NUMEL_WAIT,
        S_NUMEL_END,
        S_SAME,
        S_CONT_INIT,
        S_CONT_WR,
        S_CONT_WAIT,
        S_TNUM_GO,
        S_TNUM_WAIT,
        S_CHK,
        S_CHK_WAIT,
        S_VTEST,
        S_VSTR_WAIT,
        S_VNUM_WAIT,
        S_EMIT
    } t_state;

    // Where the emitted strides come from
    typedef enum logic [1:0] {
        OUT_FAIL,
        OUT_ONES,
        OUT_OLD,
        OUT_RES
    } t_outcome;

    // Request to the shared multiplier
    typedef struct packed {
        logic                start;
        logic [STRIDE_W-1:0] a;
        logic [STRIDE_W-1:0] b;
    } t_mul_req;

    // Answer of the shared multiplier
    typedef struct packed {
        logic                done;
        logic [STRIDE_W-1:0] p;
    } t_mul_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/tvsc_mul.sv
// Iterative 64x64 multiplier giving the low 64 bits of the product.
// One 32x32 multiplier, three passes per product; uses tvsc_pkg.
`default_nettype none

module tvsc_mul
    import tvsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [MUL_STEP_W-1:0] r_step;
    logic [STRIDE_W-1:0]   r_a;
    logic [STRIDE_W-1:0]   r_b;
    logic [STRIDE_W-1:0]   r_acc;

    logic [SIZE_W-1:0]     w_x;
    logic [SIZE_W-1:0]     w_y;
    logic [STRIDE_W-1:0]   w_prod;
    logic                  w_final;

    // Pick the halves: lo*lo, then hi*lo, then lo*hi; hi*hi falls off the top
    always_comb begin
        w_x = r_a[SIZE_W-1:0];
        w_y = r_b[SIZE_W-1:0];
        if (r_step == MUL_STEP_W'(1)) begin
            w_x = r_a[STRIDE_W-1:SIZE_W];
        end else if (r_step == MUL_STEP_W'(2)) begin
            w_y = r_b[STRIDE_W-1:SIZE_W];
        end
    end

    assign w_prod  = STRIDE_W'(w_x) * STRIDE_W'(w_y);
    assign w_final = (r_step == MUL_STEP_W'(MUL_STEPS - 1));

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_final) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            if (r_step == '0) begin
                r_acc <= w_prod;
            end else begin
                r_acc <= r_acc + {w_prod[SIZE_W-1:0], {SIZE_W{1'b0}}};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

`default_nettype wire

>>> hw/rtl/tensor_view_stride_compute.sv
// Tensor view stride computation: loads old and new shapes, emits new strides.
// Uses tvsc_pkg and one shared tvsc_mul instance.
//
// Words arrive outermost dimension first, one per cycle, each carrying an old
// dimension (size and stride), a new dimension (size), both or neither; the
// word with tlast set closes the load. The block then drops ready and works
// through the shapes with a single shared 64-bit multiplier built from one
// 32x32 multiplier in three passes. Computation first forms the element count
// over the old dimensions, then runs the chunk walk (or builds contiguous
// strides), after which one result word per new dimension leaves at one per
// cycle while the receiver holds tready high, the final one with tlast. A
// failed view or a rank above MAX_RANK gives a single word with ok cleared;
// an empty new shape that is a valid view gives a single word with
// empty_view set. All products wrap modulo 2^64. A result word may wait in
// the output register while the next load is already being taken.
`default_nettype none

module tensor_view_stride_compute
    import tvsc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input words
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // old_size[31:0], old_stride[95:32],
                                               // new_size[127:96]
    input  wire logic [1:0]   i_s_axis_tuser,  // old_present[0], new_present[1]
    input  wire logic         i_s_axis_tlast,  // last_dim
    // Result words
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [71:0]       o_m_axis_tdata,  // view_stride[63:0], dim_index[66:64],
                                               // zero pad[71:67]
    output logic [1:0]        o_m_axis_tuser,  // ok[0], empty_view[1]
    output logic              o_m_axis_tlast   // last_result
);

    // Dimension stores
    logic [SIZE_W-1:0]   r_old_size   [MAX_RANK];
    logic [STRIDE_W-1:0] r_old_stride [MAX_RANK];
    logic [SIZE_W-1:0]   r_new_size   [MAX_RANK];
    logic [STRIDE_W-1:0] r_res        [MAX_RANK];

    // Control
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_ocnt, n_ocnt;
    logic [CNT_W-1:0]    r_ncnt, n_ncnt;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_k, n_k;
    logic                r_o_valid;

    // Walk registers; r_tnum also holds the element count and the contiguous stride
    logic [CNT_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_td, n_td;
    logic [CNT_W-1:0]    r_vcnt, n_vcnt;
    logic [STRIDE_W-1:0] r_tnum, n_tnum;
    logic [STRIDE_W-1:0] r_vnum, n_vnum;
    logic [STRIDE_W-1:0] r_base, n_base;
    t_outcome            r_outcome, n_outcome;

    // Output register payload
    logic [STRIDE_W-1:0] r_o_stride;
    logic [DIM_W-1:0]    r_o_dim;
    logic                r_o_ok;
    logic                r_o_empty;
    logic                r_o_last;

    // Shared multiplier
    t_mul_req            w_req;
    t_mul_rsp            w_rsp;

    logic                w_s_fire;
    logic                w_old_full;
    logic                w_new_full;
    logic                w_slot_free;
    logic [IDX_W-1:0]    w_td_m1;
    logic [IDX_W-1:0]    w_os_idx;
    logic [IDX_W-1:0]    w_ost_idx;
    logic [IDX_W-1:0]    w_ns_idx;
    logic [IDX_W-1:0]    w_k_idx;
    logic [SIZE_W-1:0]   w_os;
    logic [STRIDE_W-1:0] w_ost;
    logic [SIZE_W-1:0]   w_ns;
    logic                w_same_last;
    logic                w_size_diff;
    logic                w_vcond;
    logic                w_emit_last;
    logic                w_res_we;
    logic [IDX_W-1:0]    w_res_idx;
    logic [STRIDE_W-1:0] w_res_data;
    logic [STRIDE_W-1:0] w_e_stride;
    logic [DIM_W-1:0]    w_e_dim;
    logic                w_e_ok;
    logic                w_e_empty;

    tvsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_old_full      = (r_ocnt == CNT_W'(MAX_RANK));
    assign w_new_full      = (r_ncnt == CNT_W'(MAX_RANK));
    assign w_slot_free     = !r_o_valid || i_m_axis_tready;
    assign w_td_m1         = r_td - 1'b1;
    assign w_k_idx         = r_k[IDX_W-1:0];

    // Select read addresses per state
    always_comb begin
        w_os_idx  = r_i[IDX_W-1:0];
        w_ost_idx = w_td_m1;
        w_ns_idx  = IDX_W'(r_vcnt - 1'b1);
        case (r_state)
            S_TNUM_GO:   w_os_idx  = r_td;
            S_CHK:       w_os_idx  = w_td_m1;
            default:     w_os_idx  = r_i[IDX_W-1:0];
        endcase
        case (r_state)
            S_NUMEL_END: w_ost_idx = IDX_W'(r_ocnt - 1'b1);
            S_EMIT:      w_ost_idx = w_k_idx;
            default:     w_ost_idx = w_td_m1;
        endcase
        case (r_state)
            S_SAME:      w_ns_idx  = r_i[IDX_W-1:0];
            S_CONT_WR:   w_ns_idx  = IDX_W'(r_i - 1'b1);
            default:     w_ns_idx  = IDX_W'(r_vcnt - 1'b1);
        endcase
    end

    assign w_os  = r_old_size[w_os_idx];
    assign w_ost = r_old_stride[w_ost_idx];
    assign w_ns  = r_new_size[w_ns_idx];

    assign w_size_diff = (r_old_size[r_i[IDX_W-1:0]] != w_ns);
    assign w_same_last = (CNT_W'(r_i + 1'b1) == r_ocnt);
    assign w_vcond     = (r_vcnt != '0) && ((r_vnum < r_tnum) || (w_ns == SIZE_W'(1)));
    assign w_emit_last = (r_outcome == OUT_FAIL) || (r_ncnt == '0) ||
                         (CNT_W'(r_k + 1'b1) == r_ncnt);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_s_fire && i_s_axis_tlast) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_ovf || r_ocnt == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_NUMEL_GO;
                end
            end
            S_NUMEL_GO: n_state = S_NUMEL_WAIT;
            S_NUMEL_WAIT: begin
                if (w_rsp.done) begin
                    n_state = w_same_last ? S_NUMEL_END : S_NUMEL_GO;
                end
            end
            S_NUMEL_END: begin
                if (r_tnum != '0) begin
                    n_state = S_TNUM_GO;
                end else if (r_ocnt != r_ncnt) begin
                    n_state = S_CONT_INIT;
                end else begin
                    n_state = S_SAME;
                end
            end
            S_SAME: begin
                if (w_size_diff) begin
                    n_state = S_CONT_INIT;
                end else if (w_same_last) begin
                    n_state = S_EMIT;
                end
            end
            S_CONT_INIT: n_state = (r_ncnt == '0) ? S_EMIT : S_CONT_WR;
            S_CONT_WR: begin
                n_state = (r_i == CNT_W'(1)) ? S_EMIT : S_CONT_WAIT;
            end
            S_CONT_WAIT: begin
                if (w_rsp.done) begin
                    n_state = S_CONT_WR;
                end
            end
            S_TNUM_GO: n_state = S_TNUM_WAIT;
            S_TNUM_WAIT: begin
                if (w_rsp.done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_td == '0) begin
                    n_state = S_VTEST;
                end else if (w_os == SIZE_W'(1)) begin
                    n_state = S_TNUM_GO;
                end else begin
                    n_state = S_CHK_WAIT;
                end
            end
            S_CHK_WAIT: begin
                if (w_rsp.done) begin
                    n_state = (w_rsp.p != w_ost) ? S_VTEST : S_TNUM_GO;
                end
            end
            S_VTEST: begin
                if (w_vcond) begin
                    n_state = S_VSTR_WAIT;
                end else if (r_vnum != r_tnum || r_td == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TNUM_GO;
                end
            end
            S_VSTR_WAIT: begin
                if (w_rsp.done) begin
                    n_state = S_VNUM_WAIT;
                end
            end
            S_VNUM_WAIT: begin
                if (w_rsp.done) begin
                    n_state = S_VTEST;
                end
            end
            S_EMIT: begin
                if (w_slot_free && w_emit_last) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Next values of counts and walk registers
    always_comb begin
        n_ocnt    = r_ocnt;
        n_ncnt    = r_ncnt;
        n_ovf     = r_ovf;
        n_k       = r_k;
        n_i       = r_i;
        n_td      = r_td;
        n_vcnt    = r_vcnt;
        n_tnum    = r_tnum;
        n_vnum    = r_vnum;
        n_base    = r_base;
        n_outcome = r_outcome;
        case (r_state)
            S_LOAD: begin
                if (w_s_fire && i_s_axis_tuser[0]) begin
                    if (w_old_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_ocnt = r_ocnt + 1'b1;
                    end
                end
                if (w_s_fire && i_s_axis_tuser[1]) begin
                    if (w_new_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_ncnt = r_ncnt + 1'b1;
                    end
                end
            end
            S_START: begin
                if (r_ovf) begin
                    n_outcome = OUT_FAIL;
                end else if (r_ocnt == '0) begin
                    n_outcome = OUT_ONES;
                end else begin
                    n_tnum = STRIDE_W'(1);
                    n_i    = '0;
                end
            end
            S_NUMEL_WAIT: begin
                if (w_rsp.done) begin
                    n_tnum = w_rsp.p;
                    n_i    = r_i + 1'b1;
                end
            end
            S_NUMEL_END: begin
                if (r_tnum == '0) begin
                    n_i = '0;
                end else begin
                    n_base = w_ost;
                    n_tnum = STRIDE_W'(1);
                    n_vnum = STRIDE_W'(1);
                    n_td   = IDX_W'(r_ocnt - 1'b1);
                    n_vcnt = r_ncnt;
                end
            end
            S_SAME: begin
                if (!w_size_diff) begin
                    if (w_same_last) begin
                        n_outcome = OUT_OLD;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_CONT_INIT: begin
                n_tnum    = STRIDE_W'(1);
                n_i       = r_ncnt;
                n_outcome = OUT_RES;
            end
            S_CONT_WAIT: begin
                if (w_rsp.done) begin
                    n_tnum = w_rsp.p;
                    n_i    = r_i - 1'b1;
                end
            end
            S_TNUM_WAIT: begin
                if (w_rsp.done) begin
                    n_tnum = w_rsp.p;
                end
            end
            S_CHK: begin
                if (r_td != '0 && w_os == SIZE_W'(1)) begin
                    n_td = w_td_m1;
                end
            end
            S_CHK_WAIT: begin
                if (w_rsp.done && w_rsp.p == w_ost) begin
                    n_td = w_td_m1;
                end
            end
            S_VTEST: begin
                if (!w_vcond) begin
                    if (r_vnum != r_tnum) begin
                        n_outcome = OUT_FAIL;
                    end else if (r_td != '0) begin
                        n_base = w_ost;
                        n_tnum = STRIDE_W'(1);
                        n_vnum = STRIDE_W'(1);
                        n_td   = w_td_m1;
                    end else begin
                        n_outcome = (r_vcnt == '0) ? OUT_RES : OUT_FAIL;
                    end
                end
            end
            S_VNUM_WAIT: begin
                if (w_rsp.done) begin
                    n_vnum = w_rsp.p;
                    n_vcnt = r_vcnt - 1'b1;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    if (w_emit_last) begin
                        n_ocnt = '0;
                        n_ncnt = '0;
                        n_ovf  = 1'b0;
                        n_k    = '0;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase
    end

    // Multiplier requests and result-store writes
    always_comb begin
        w_req      = '0;
        w_res_we   = 1'b0;
        w_res_idx  = IDX_W'(r_vcnt - 1'b1);
        w_res_data = w_rsp.p;
        case (r_state)
            S_NUMEL_GO, S_TNUM_GO: begin
                w_req.start = 1'b1;
                w_req.a     = r_tnum;
                w_req.b     = STRIDE_W'(w_os);
            end
            S_CONT_WR: begin
                w_res_we    = 1'b1;
                w_res_idx   = IDX_W'(r_i - 1'b1);
                w_res_data  = r_tnum;
                w_req.start = (r_i != CNT_W'(1));
                w_req.a     = r_tnum;
                w_req.b     = STRIDE_W'(w_ns);
            end
            S_CHK: begin
                w_req.start = (r_td != '0) && (w_os != SIZE_W'(1));
                w_req.a     = r_base;
                w_req.b     = r_tnum;
            end
            S_VTEST: begin
                w_req.start = w_vcond;
                w_req.a     = r_base;
                w_req.b     = r_vnum;
            end
            S_VSTR_WAIT: begin
                w_res_we    = w_rsp.done;
                w_req.start = w_rsp.done;
                w_req.a     = r_vnum;
                w_req.b     = STRIDE_W'(w_ns);
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // Build the next result word
    always_comb begin
        w_e_stride = '0;
        w_e_dim    = '0;
        w_e_ok     = 1'b1;
        w_e_empty  = 1'b0;
        if (r_outcome == OUT_FAIL) begin
            w_e_ok = 1'b0;
        end else if (r_ncnt == '0) begin
            w_e_empty = 1'b1;
        end else begin
            w_e_dim = DIM_W'(r_k);
            case (r_outcome)
                OUT_ONES: w_e_stride = STRIDE_W'(1);
                OUT_OLD:  w_e_stride = w_ost;
                OUT_RES:  w_e_stride = r_res[w_k_idx];
                default:  w_e_stride = '0;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_ocnt    <= '0;
            r_ncnt    <= '0;
            r_ovf     <= 1'b0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ocnt  <= n_ocnt;
            r_ncnt  <= n_ncnt;
            r_ovf   <= n_ovf;
            r_k     <= n_k;
            if (r_state == S_EMIT && w_slot_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Walk registers and output payload
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_td      <= n_td;
        r_vcnt    <= n_vcnt;
        r_tnum    <= n_tnum;
        r_vnum    <= n_vnum;
        r_base    <= n_base;
        r_outcome <= n_outcome;
        if (r_state == S_EMIT && w_slot_free) begin
            r_o_stride <= w_e_stride;
            r_o_dim    <= w_e_dim;
            r_o_ok     <= w_e_ok;
            r_o_empty  <= w_e_empty;
            r_o_last   <= w_emit_last;
        end
    end

    // Dimension stores: append on load, result strides from the sequencer
    always_ff @(posedge i_clk) begin
        if (w_s_fire && i_s_axis_tuser[0] && !w_old_full) begin
            r_old_size[r_ocnt[IDX_W-1:0]]   <= i_s_axis_tdata[31:0];
            r_old_stride[r_ocnt[IDX_W-1:0]] <= i_s_axis_tdata[95:32];
        end
        if (w_s_fire && i_s_axis_tuser[1] && !w_new_full) begin
            r_new_size[r_ncnt[IDX_W-1:0]] <= i_s_axis_tdata[127:96];
        end
        if (w_res_we) begin
            r_res[w_res_idx] <= w_res_data;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {5'b0, r_o_dim, r_o_stride};
    assign o_m_axis_tuser  = {r_o_empty, r_o_ok};
    assign o_m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire
